@@ rtl/core/d2q_pkg.sv @@
// Shared constants and lattice direction tables for the D2Q9 collision cell.
package d2q_pkg;

    localparam int RATE_BITS = 30;
    localparam int NDIR      = 9;

    typedef enum logic [1:0] {
        WC_REST,
        WC_AXIS,
        WC_DIAG
    } t_wclass;

    localparam int      DIR_CX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    localparam int      DIR_CY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    localparam t_wclass DIR_WC [NDIR] = '{WC_REST, WC_AXIS, WC_AXIS, WC_AXIS, WC_AXIS,
                                          WC_DIAG, WC_DIAG, WC_DIAG, WC_DIAG};

endpackage

@@ rtl/core/d2q_if.sv @@
// Channel interfaces: cell input, cell result and relax rate write.
interface d2q_cell_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] f_rest;
    logic signed [W-1:0] f_east;
    logic signed [W-1:0] f_north;
    logic signed [W-1:0] f_west;
    logic signed [W-1:0] f_south;
    logic signed [W-1:0] f_northeast;
    logic signed [W-1:0] f_northwest;
    logic signed [W-1:0] f_southwest;
    logic signed [W-1:0] f_southeast;
    logic                solid;

    modport source (output valid, f_rest, f_east, f_north, f_west, f_south, f_northeast,
                    f_northwest, f_southwest, f_southeast, solid, input ready);
    modport sink   (input valid, f_rest, f_east, f_north, f_west, f_south, f_northeast,
                    f_northwest, f_southwest, f_southeast, solid, output ready);
endinterface

interface d2q_res_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] g_rest;
    logic signed [W-1:0] g_east;
    logic signed [W-1:0] g_north;
    logic signed [W-1:0] g_west;
    logic signed [W-1:0] g_south;
    logic signed [W-1:0] g_northeast;
    logic signed [W-1:0] g_northwest;
    logic signed [W-1:0] g_southwest;
    logic signed [W-1:0] g_southeast;
    logic signed [W-1:0] density;
    logic signed [W-1:0] vel_x;
    logic signed [W-1:0] vel_y;

    modport source (output valid, g_rest, g_east, g_north, g_west, g_south, g_northeast,
                    g_northwest, g_southwest, g_southeast, density, vel_x, vel_y,
                    input ready);
    modport sink   (input valid, g_rest, g_east, g_north, g_west, g_south, g_northeast,
                    g_northwest, g_southwest, g_southeast, density, vel_x, vel_y,
                    output ready);
endinterface

interface d2q_cfg_if;
    import d2q_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [RATE_BITS-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/d2q_qmul.sv @@
// Two-stage fixed-point multiply: exact product, then round half away and saturate.
module d2q_qmul #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int W  = 32,
    parameter int F  = 28
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [W-1:0]  o_p
);
    localparam int PW = AW + BW;
    localparam int RW = PW + 1 - F;

    logic [AW-1:0] ua;
    logic [BW-1:0] ub;
    logic          r_neg;
    logic [PW-1:0] r_mag;
    logic [PW:0]   rsum;
    logic [RW-1:0] rnd;
    logic [RW-1:0] lim;
    logic [RW-1:0] mag;
    logic [W-1:0]  mag_n;

    assign ua = i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
    assign ub = i_b[BW-1] ? BW'(-i_b) : BW'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_a[AW-1] ^ i_b[BW-1];
            r_mag <= PW'(ua) * PW'(ub);
        end
    end

    always_comb begin
        rsum  = {1'b0, r_mag} + ((PW+1)'(1) << (F - 1));
        rnd   = RW'(rsum >> F);
        lim   = r_neg ? RW'({1'b1, {(W-1){1'b0}}}) : RW'({1'b0, {(W-1){1'b1}}});
        mag   = (rnd > lim) ? lim : rnd;
        mag_n = -mag[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= r_neg ? mag_n : mag[W-1:0];
        end
    end
endmodule

@@ rtl/core/d2q_udiv.sv @@
// Pipelined restoring divider: num * 2^F / den, one quotient bit per stage.
module d2q_udiv #(
    parameter int W = 32,
    parameter int F = 28
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W+1:0] i_num,
    input  logic [W-2:0] i_den,
    output logic [W:0]   o_quo,
    output logic         o_ovf
);
    localparam int QB = W + 1;
    localparam int SH = QB - F;
    localparam int CW = W + 2 + SH;

    logic [W-2:0]  r_rem [0:QB];
    logic [QB-1:0] r_quo [0:QB];
    logic [QB-1:0] r_dvd [0:QB];
    logic [W-2:0]  r_den [0:QB];
    logic          r_ovf [0:QB];

    // flag quotients that cannot fit before the bit loop starts
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= CW'(i_num) >= CW'({i_den, {SH{1'b0}}});
            r_rem[0] <= (W-1)'(i_num >> SH);
            r_dvd[0] <= {i_num[SH-1:0], {F{1'b0}}};
            r_quo[0] <= '0;
            r_den[0] <= i_den;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [W-1:0] t;
        logic [W-1:0] d;
        logic         ge;

        assign t  = {r_rem[j-1], r_dvd[j-1][QB-1]};
        assign d  = {1'b0, r_den[j-1]};
        assign ge = t >= d;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? (W-1)'(t - d) : t[W-2:0];
                r_quo[j] <= {r_quo[j-1][QB-2:0], ge};
                r_dvd[j] <= {r_dvd[j-1][QB-2:0], 1'b0};
                r_den[j] <= r_den[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    assign o_quo = r_quo[QB];
    assign o_ovf = r_ovf[QB];
endmodule

@@ rtl/core/d2q9_bgk_collision_cell_top.sv @@
// D2Q9 BGK collision kernel: one lattice cell per cycle through a deep pipeline.
// Most of the pipeline depth lies in the velocity dividers, DATA_WIDTH + 1 bit steps each.
// Throughput: one cell per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears stage valid bits and sets omega to 1.0.
module d2q9_bgk_collision_cell_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 28
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    d2q_cell_if.sink   i_cell,
    d2q_res_if.source  o_cell,
    d2q_cfg_if.sink    i_cfg
);
    import d2q_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int QB  = W + 1;
    localparam int NW  = W + 2;
    localparam int SW  = W + 4;
    localparam int MW  = W + 3;
    localparam int XW  = W + 8;
    localparam int DW  = W + 1;

    localparam int T_SUM  = 1;
    localparam int T_RHO  = 2;
    localparam int T_DIV  = T_RHO + QB + 1;
    localparam int T_U    = T_DIV + 1;
    localparam int T_CU   = T_U + 1;
    localparam int T_SQ   = T_CU + 2;
    localparam int T_T2   = T_SQ + 1;
    localparam int T_POLY = T_T2 + 1;
    localparam int T_FEQ  = T_POLY + 2;
    localparam int T_DIFF = T_FEQ + 1;
    localparam int T_RLX  = T_DIFF + 2;
    localparam int T_G    = T_RLX + 1;
    localparam int NST    = T_G + 1;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE  = W'(64'd1 << F);
    localparam logic signed [W-1:0] WT_REST = W'(((64'd4 << F) + 64'd4) / 64'd9);
    localparam logic signed [W-1:0] WT_AXIS = W'(((64'd1 << F) + 64'd4) / 64'd9);
    localparam logic signed [W-1:0] WT_DIAG = W'(((64'd1 << F) + 64'd18) / 64'd36);
    localparam logic [RATE_BITS-1:0] OMEGA_RST = RATE_BITS'(64'd1 << F);

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] x);
        if (x > XW'(MAXV)) return MAXV;
        if (x < XW'(MINV)) return MINV;
        return x[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] fix_u(input logic ovf, input logic neg,
                                                   input logic [QB-1:0] q);
        logic [QB-1:0] lim;
        logic [QB-1:0] mag;
        logic [QB-1:0] mag_n;
        lim   = neg ? QB'({1'b1, {(W-1){1'b0}}}) : QB'({1'b0, {(W-1){1'b1}}});
        mag   = (ovf || q > lim) ? lim : q;
        mag_n = -mag;
        return neg ? mag_n[W-1:0] : mag[W-1:0];
    endfunction

    logic                  en;
    logic [NST-1:0]        r_vld;
    logic [RATE_BITS-1:0]  r_omega;

    logic signed [W-1:0]   r_f     [0:T_RLX][NDIR];
    logic                  r_solid [0:T_SUM];
    logic signed [SW-1:0]  r_sum;
    logic signed [MW-1:0]  r_mx;
    logic signed [MW-1:0]  r_my;
    logic signed [W-1:0]   r_rho   [T_RHO:T_G];
    logic                  r_divok [T_RHO:T_DIV];
    logic                  r_negx  [T_RHO:T_DIV];
    logic                  r_negy  [T_RHO:T_DIV];
    logic [NW-1:0]         r_umx;
    logic [NW-1:0]         r_umy;
    logic signed [W-1:0]   r_ux    [T_U:T_G];
    logic signed [W-1:0]   r_uy    [T_U:T_G];
    logic signed [W-1:0]   r_cu    [T_CU:T_POLY][NDIR];
    logic signed [W-1:0]   r_rhow  [T_SQ+1:T_POLY][3];
    logic signed [W-1:0]   r_usq;
    logic signed [XW-1:0]  r_t2    [NDIR];
    logic signed [W-1:0]   r_poly  [NDIR];
    logic signed [DW-1:0]  r_diff  [NDIR];
    logic signed [W-1:0]   r_g     [NDIR];

    logic [QB-1:0]         quo_x, quo_y;
    logic                  ovf_x, ovf_y;
    logic signed [W-1:0]   cu2   [NDIR];
    logic signed [W-1:0]   feq   [NDIR];
    logic signed [W-1:0]   prod  [NDIR];
    logic signed [W-1:0]   rhow  [3];
    logic signed [W-1:0]   wts   [3];
    logic signed [W-1:0]   uxx, uyy;
    logic signed [XW-1:0]  sum_c, mx_c, my_c;
    logic signed [W-1:0]   rho_c;
    logic signed [W-1:0]   cu_c  [NDIR];
    logic signed [RATE_BITS:0] omega_s;

    // hold every stage while the result register waits
    assign en           = !r_vld[NST-1] || o_cell.ready;
    assign i_cell.ready = en;
    assign i_cfg.ready  = 1'b1;
    assign omega_s      = {1'b0, r_omega};
    assign wts          = '{WT_REST, WT_AXIS, WT_DIAG};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_omega <= OMEGA_RST;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NST-2:0], i_cell.valid};
            end
            if (i_cfg.valid) begin
                r_omega <= i_cfg.data;
            end
        end
    end

    always_comb begin
        sum_c = '0;
        mx_c  = '0;
        my_c  = '0;
        for (int k = 0; k < NDIR; k++) begin
            sum_c = sum_c + XW'(r_f[0][k]);
            if (DIR_CX[k] == 1)       mx_c = mx_c + XW'(r_f[0][k]);
            else if (DIR_CX[k] == -1) mx_c = mx_c - XW'(r_f[0][k]);
            if (DIR_CY[k] == 1)       my_c = my_c + XW'(r_f[0][k]);
            else if (DIR_CY[k] == -1) my_c = my_c - XW'(r_f[0][k]);
        end
        rho_c = sat_w(XW'(r_sum));
        for (int k = 0; k < NDIR; k++) begin
            logic signed [XW-1:0] acc;
            acc = '0;
            if (DIR_CX[k] == 1)       acc = acc + XW'(r_ux[T_U]);
            else if (DIR_CX[k] == -1) acc = acc - XW'(r_ux[T_U]);
            if (DIR_CY[k] == 1)       acc = acc + XW'(r_uy[T_U]);
            else if (DIR_CY[k] == -1) acc = acc - XW'(r_uy[T_U]);
            cu_c[k] = sat_w(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f[0] <= '{i_cell.f_rest, i_cell.f_east, i_cell.f_north, i_cell.f_west,
                        i_cell.f_south, i_cell.f_northeast, i_cell.f_northwest,
                        i_cell.f_southwest, i_cell.f_southeast};
            for (int s = 1; s <= T_RLX; s++) r_f[s] <= r_f[s-1];
            r_solid[0] <= i_cell.solid;
            r_solid[1] <= r_solid[0];

            r_sum <= SW'(sum_c);
            r_mx  <= MW'(mx_c);
            r_my  <= MW'(my_c);

            // density, division enable and momentum magnitudes
            r_rho[T_RHO]   <= rho_c;
            r_divok[T_RHO] <= !r_solid[T_SUM] && !rho_c[W-1] && (rho_c != '0);
            r_negx[T_RHO]  <= r_mx[MW-1];
            r_negy[T_RHO]  <= r_my[MW-1];
            r_umx          <= r_mx[MW-1] ? NW'(-r_mx) : NW'(r_mx);
            r_umy          <= r_my[MW-1] ? NW'(-r_my) : NW'(r_my);
            for (int s = T_RHO + 1; s <= T_G; s++)   r_rho[s]   <= r_rho[s-1];
            for (int s = T_RHO + 1; s <= T_DIV; s++) begin
                r_divok[s] <= r_divok[s-1];
                r_negx[s]  <= r_negx[s-1];
                r_negy[s]  <= r_negy[s-1];
            end

            r_ux[T_U] <= r_divok[T_DIV] ? fix_u(ovf_x, r_negx[T_DIV], quo_x) : '0;
            r_uy[T_U] <= r_divok[T_DIV] ? fix_u(ovf_y, r_negy[T_DIV], quo_y) : '0;
            for (int s = T_U + 1; s <= T_G; s++) begin
                r_ux[s] <= r_ux[s-1];
                r_uy[s] <= r_uy[s-1];
            end

            r_cu[T_CU] <= cu_c;
            for (int s = T_CU + 1; s <= T_POLY; s++) r_cu[s] <= r_cu[s-1];
            r_rhow[T_SQ+1] <= rhow;
            for (int s = T_SQ + 2; s <= T_POLY; s++) r_rhow[s] <= r_rhow[s-1];

            r_usq <= sat_w(XW'(uxx) + XW'(uyy));
            for (int k = 0; k < NDIR; k++) begin
                r_t2[k] <= ((XW'(cu2[k]) <<< 3) + XW'(cu2[k]) + XW'(1)) >>> 1;
            end

            for (int k = 0; k < NDIR; k++) begin
                logic signed [XW-1:0] t3;
                t3 = ((XW'(r_usq) <<< 1) + XW'(r_usq) + XW'(1)) >>> 1;
                r_poly[k] <= sat_w(XW'(ONE) + (XW'(r_cu[T_T2][k]) <<< 1)
                                   + XW'(r_cu[T_T2][k]) + r_t2[k] - t3);
            end

            for (int k = 0; k < NDIR; k++) begin
                r_diff[k] <= DW'(r_f[T_FEQ][k]) - DW'(feq[k]);
                r_g[k]    <= sat_w(XW'(r_f[T_RLX][k]) - XW'(prod[k]));
            end
        end
    end

    d2q_udiv #(.W(W), .F(F)) u_div_x (
        .i_clk (i_clk), .i_en (en), .i_num (r_umx), .i_den (r_rho[T_RHO][W-2:0]),
        .o_quo (quo_x), .o_ovf (ovf_x)
    );
    d2q_udiv #(.W(W), .F(F)) u_div_y (
        .i_clk (i_clk), .i_en (en), .i_num (r_umy), .i_den (r_rho[T_RHO][W-2:0]),
        .o_quo (quo_y), .o_ovf (ovf_y)
    );

    d2q_qmul #(.AW(W), .BW(W), .W(W), .F(F)) u_uxx (
        .i_clk (i_clk), .i_en (en), .i_a (r_ux[T_CU]), .i_b (r_ux[T_CU]), .o_p (uxx)
    );
    d2q_qmul #(.AW(W), .BW(W), .W(W), .F(F)) u_uyy (
        .i_clk (i_clk), .i_en (en), .i_a (r_uy[T_CU]), .i_b (r_uy[T_CU]), .o_p (uyy)
    );

    for (genvar c = 0; c < 3; c++) begin : g_rhow
        d2q_qmul #(.AW(W), .BW(W), .W(W), .F(F)) u_rhow (
            .i_clk (i_clk), .i_en (en), .i_a (r_rho[T_CU]), .i_b (wts[c]), .o_p (rhow[c])
        );
    end

    for (genvar k = 0; k < NDIR; k++) begin : g_dir
        d2q_qmul #(.AW(W), .BW(W), .W(W), .F(F)) u_cu2 (
            .i_clk (i_clk), .i_en (en), .i_a (r_cu[T_CU][k]), .i_b (r_cu[T_CU][k]),
            .o_p (cu2[k])
        );
        d2q_qmul #(.AW(W), .BW(W), .W(W), .F(F)) u_feq (
            .i_clk (i_clk), .i_en (en), .i_a (r_rhow[T_POLY][int'(DIR_WC[k])]),
            .i_b (r_poly[k]), .o_p (feq[k])
        );
        d2q_qmul #(.AW(RATE_BITS + 1), .BW(DW), .W(W), .F(F)) u_relax (
            .i_clk (i_clk), .i_en (en), .i_a (omega_s), .i_b (r_diff[k]), .o_p (prod[k])
        );
    end

    assign o_cell.valid       = r_vld[NST-1];
    assign o_cell.g_rest      = r_g[0];
    assign o_cell.g_east      = r_g[1];
    assign o_cell.g_north     = r_g[2];
    assign o_cell.g_west      = r_g[3];
    assign o_cell.g_south     = r_g[4];
    assign o_cell.g_northeast = r_g[5];
    assign o_cell.g_northwest = r_g[6];
    assign o_cell.g_southwest = r_g[7];
    assign o_cell.g_southeast = r_g[8];
    assign o_cell.density     = r_rho[T_G];
    assign o_cell.vel_x       = r_ux[T_G];
    assign o_cell.vel_y       = r_uy[T_G];
endmodule

@@ rtl/core/d2q_checker.sv @@
// Port-level checks for the collision cell, bound to the top level.
module d2q_checker #(
    parameter int W = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] out_density
);
    // a stalled result must stay offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // pipeline advances whenever the result side is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input stalled with free output");

    // a stalled output holds the input side too
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken during output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result offered right after reset");

    // an offered result carries a known density
    a_density_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !$isunknown(out_density))
        else $error("unknown density on offered result");
endmodule

bind d2q9_bgk_collision_cell_top d2q_checker #(.W(DATA_WIDTH)) u_d2q_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_ready    (i_cell.ready),
    .out_valid   (o_cell.valid),
    .out_ready   (o_cell.ready),
    .out_density (o_cell.density)
);
